// ===== src/fdwc_pkg.sv =====
`timescale 1ns / 1ps

package fdwc_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int SEQ_W  = 3;   // result index within one item, up to six results

  localparam logic [CRC_W-1:0] CRC_PRESET_MFM = 16'hCDB4;
  localparam logic [CRC_W-1:0] CRC_PRESET_FM  = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY       = 16'h1021;

  // APB register map
  localparam int                ADDR_W         = 3;
  localparam logic              REG_DENSITY    = 1'b0;
  localparam logic              REG_DOUBLING   = 1'b1;

  // Byte group within one item's results
  localparam logic [1:0] GRP_DATA   = 2'd0;
  localparam logic [1:0] GRP_CRC_HI = 2'd1;
  localparam logic [1:0] GRP_CRC_LO = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [CRC_W-1:0]  crc;
    logic              last;
    logic              dbl;
  } item_t;

  // MSB-first CRC-16 update over one byte
  function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0]  c;
    logic [BYTE_W-1:0] d;
    logic              fb;
    c = crc;
    d = b;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = c[CRC_W-1] ^ d[BYTE_W-1];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
      d = {d[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== src/fdwc_if.sv =====
`timescale 1ns / 1ps

interface fdwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_field;
  logic       last_of_field;

  modport source (output valid, data_byte, first_of_field, last_of_field, input ready);
  modport sink (input valid, data_byte, first_of_field, last_of_field, output ready);
endinterface

interface fdwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       is_crc_byte;
  logic       end_of_run;

  modport source (output valid, track_byte, is_crc_byte, end_of_run, input ready);
  modport sink (input valid, track_byte, is_crc_byte, end_of_run, output ready);
endinterface

// ===== src/fdwc_cfg.sv =====
`timescale 1ns / 1ps

module fdwc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fdwc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic                       double_density,
  output logic                       byte_doubling
);
  import fdwc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_density <= 1'b0;
      byte_doubling  <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == REG_DENSITY) begin
        double_density <= pwdata[0];
      end
      if (paddr[2] == REG_DOUBLING) begin
        byte_doubling <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DENSITY) begin
      prdata[0] = double_density;
    end else begin
      prdata[0] = byte_doubling;
    end
  end

endmodule

// ===== src/fdwc_crc_unit.sv =====
`timescale 1ns / 1ps

module fdwc_crc_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [fdwc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        first,
  input  logic                        double_density,
  output logic [fdwc_pkg::CRC_W-1:0]  crc_next
);
  import fdwc_pkg::*;

  logic [CRC_W-1:0] crc_value;
  logic [CRC_W-1:0] crc_base;

  // restart from the preset on a mark byte
  assign crc_base = first ? (double_density ? CRC_PRESET_MFM : CRC_PRESET_FM) : crc_value;
  assign crc_next = crc_add_byte(crc_base, data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value <= CRC_PRESET_FM;
    end else if (accept) begin
      crc_value <= crc_next;
    end
  end

endmodule

// ===== src/fdwc_emitter.sv =====
`timescale 1ns / 1ps

module fdwc_emitter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  fdwc_pkg::item_t             item,
  output logic                        item_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fdwc_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_crc,
  output logic                        out_end
);
  import fdwc_pkg::*;

  item_t            hold;
  logic             hold_valid;
  logic [SEQ_W-1:0] seq;
  logic [SEQ_W-1:0] res_count;
  logic [1:0]       grp;
  logic             res_end;
  logic             load;
  logic [BYTE_W-1:0] res_byte;

  always_comb begin
    case ({hold.last, hold.dbl})
      2'b00:   res_count = SEQ_W'(1);
      2'b01:   res_count = SEQ_W'(2);
      2'b10:   res_count = SEQ_W'(3);
      default: res_count = SEQ_W'(6);
    endcase
  end

  assign grp     = hold.dbl ? seq[2:1] : seq[1:0];
  assign res_end = (seq == res_count - SEQ_W'(1));
  assign load    = hold_valid & (~out_valid | out_ready);

  // take the next item as the current one sends its last result
  assign item_ready = ~hold_valid | (load & res_end);

  always_comb begin
    case (grp)
      GRP_DATA:   res_byte = hold.data_byte;
      GRP_CRC_HI: res_byte = hold.crc[CRC_W-1:BYTE_W];
      GRP_CRC_LO: res_byte = hold.crc[BYTE_W-1:0];
      default:    res_byte = hold.data_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      seq        <= '0;
    end else if (accept) begin
      hold_valid <= 1'b1;
      seq        <= '0;
    end else if (load) begin
      if (res_end) begin
        hold_valid <= 1'b0;
        seq        <= '0;
      end else begin
        seq <= seq + SEQ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= res_byte;
      out_crc  <= (grp != GRP_DATA);
      out_end  <= res_end;
    end
  end

  a_seq_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (seq < res_count))
    else $error("result index beyond item result count");

  a_crc_only_last: assert property (@(posedge clk) disable iff (rst)
    (load && !hold.last) |=> !out_crc)
    else $error("CRC byte sent for an item without last mark");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (hold_valid && seq == '0))
    else $error("accepted item not held at result zero");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !(load && res_end)) |-> !item_ready)
    else $error("ready raised while an item is still pending");

endmodule

// ===== src/floppy_data_field_writer_crc.sv =====
`timescale 1ns / 1ps

// Floppy sector data field writer. Feed the data address mark byte with
// first_of_field set, then the sector bytes, with last_of_field on the final
// one. Each item comes out as one track byte, or two with byte_doubling set,
// and the last item is followed by the CRC-16 high and low bytes (doubled
// likewise), with end_of_run on the final result of each item. The CRC
// (poly 0x1021, MSB first) restarts on a mark from 0xCDB4 when
// double_density is set, else 0xFFFF. An item gives 1 or 2 results for a
// data byte and 3 or 6 for the last one; the output register sends one byte a
// cycle while out_ready is high. The CRC update of a byte is done as it is
// taken in, so a new item is accepted while the previous one's final result
// goes out.
module floppy_data_field_writer_crc (
  input  logic                        clk,
  input  logic                        rst,
  fdwc_in_if.sink                     in_item,
  fdwc_out_if.source                  out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdwc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fdwc_pkg::*;

  logic             double_density;
  logic             byte_doubling;
  logic             accept;
  logic             item_ready;
  logic [CRC_W-1:0] crc_next;
  item_t            item;

  assign in_item.ready = item_ready;
  assign accept        = in_item.valid & item_ready;

  fdwc_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .double_density (double_density),
    .byte_doubling  (byte_doubling)
  );

  fdwc_crc_unit u_crc (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (in_item.data_byte),
    .first          (in_item.first_of_field),
    .double_density (double_density),
    .crc_next       (crc_next)
  );

  always_comb begin
    item.data_byte = in_item.data_byte;
    item.crc       = crc_next;
    item.last      = in_item.last_of_field;
    item.dbl       = byte_doubling;
  end

  fdwc_emitter u_emit (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .item_ready (item_ready),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .out_byte   (out_item.track_byte),
    .out_crc    (out_item.is_crc_byte),
    .out_end    (out_item.end_of_run)
  );

endmodule

// ===== bench/tb_floppy_data_field_writer_crc.sv =====
`timescale 1ns / 1ps

module tb_floppy_data_field_writer_crc;
  import fdwc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first;
    logic              last;
  } field_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] track_byte;
    logic              is_crc;
    logic              end_of_run;
  } track_out_t;

  localparam logic [ADDR_W-1:0] DENSITY_ADDR  = ADDR_W'(4 * int'(REG_DENSITY));
  localparam logic [ADDR_W-1:0] DOUBLING_ADDR = ADDR_W'(4 * int'(REG_DOUBLING));
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int NUM_PHASES = 9;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  fdwc_in_if  in_ch ();
  fdwc_out_if out_ch ();

  floppy_data_field_writer_crc dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_ch),
    .out_item(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow registers and running CRC of the predictor
  logic             dd_shadow;
  logic             dbl_shadow;
  logic [CRC_W-1:0] field_crc = CRC_PRESET_FM;

  field_item_t pending_items[$];
  track_out_t  track_expect_q[$];

  logic in_taken = 1'b0;
  logic hold_rx;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_taken = 0;
  int   results_seen = 0;
  int   fields_closed = 0;
  int   mismatches = 0;
  int   errors;
  int   phase_cnt;
  int   dbl_fields = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic [CRC_W-1:0] d;
    int i;
    c = crc;
    d = {b, 8'h00};
    for (i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1] ^ d[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
      d = {d[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void push_track(input logic [BYTE_W-1:0] b, input logic crc_flag);
    track_out_t t;
    t.track_byte = b;
    t.is_crc     = crc_flag;
    t.end_of_run = 1'b0;
    track_expect_q.push_back(t);
    if (dbl_shadow) begin
      track_expect_q.push_back(t);
    end
  endfunction

  function automatic void predict_track_bytes(input field_item_t it);
    track_out_t t;
    if (it.first) begin
      field_crc = dd_shadow ? CRC_PRESET_MFM : CRC_PRESET_FM;
    end
    field_crc = crc16_next(field_crc, it.data_byte);
    push_track(it.data_byte, 1'b0);
    if (it.last) begin
      push_track(field_crc[15:8], 1'b1);
      push_track(field_crc[7:0], 1'b1);
    end
    // flag the final byte of this item
    t = track_expect_q.pop_back();
    t.end_of_run = 1'b1;
    track_expect_q.push_back(t);
  endfunction

  function automatic void report_mismatch(input string what, input track_out_t want,
                                          input track_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s exp byte=%02h crc=%0b eor=%0b got byte=%02h crc=%0b eor=%0b",
               $realtime, what, want.track_byte, want.is_crc, want.end_of_run,
               got.track_byte, got.is_crc, got.end_of_run);
    end
  endfunction

  // monitor: check outputs first, then predict for the accepted item
  always @(posedge clk) begin
    track_out_t got;
    track_out_t want;
    field_item_t it;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.track_byte = out_ch.track_byte;
        got.is_crc     = out_ch.is_crc_byte;
        got.end_of_run = out_ch.end_of_run;
        if (track_expect_q.size() == 0) begin
          want = '0;
          report_mismatch("unexpected item", want, got);
        end else begin
          want = track_expect_q.pop_front();
          if (got.track_byte !== want.track_byte || got.is_crc !== want.is_crc ||
              got.end_of_run !== want.end_of_run) begin
            report_mismatch("track item", want, got);
          end
        end
      end
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        it.data_byte = in_ch.data_byte;
        it.first     = in_ch.first_of_field;
        it.last      = in_ch.last_of_field;
        items_taken++;
        if (it.last) begin
          fields_closed++;
          if (dbl_shadow) begin
            dbl_fields++;
          end
        end
        predict_track_bytes(it);
      end
    end
  end

  // driver: hold the item until taken, then advance or idle
  always @(negedge clk) begin
    field_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= it.data_byte;
        in_ch.first_of_field <= it.first;
        in_ch.last_of_field  <= it.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || hold_rx) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    hold_rx = 1'b0;
    while (items_taken < 100) @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    #3000000;
    $display("timeout with %0d items still expected", track_expect_q.size());
    $display("[floppy_data_field_writer_crc] ERROR");
    $finish;
  end

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic dd, input logic dbl);
    write_reg(DENSITY_ADDR, {31'd0, dd});
    dd_shadow = dd;
    write_reg(DOUBLING_ADDR, {31'd0, dbl});
    dbl_shadow = dbl;
  endtask

  task automatic drain_and_settle();
    while (pending_items.size() != 0 || in_ch.valid || track_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic void queue_item(input logic [BYTE_W-1:0] b, input logic first,
                                     input logic last);
    field_item_t it;
    it.data_byte = b;
    it.first     = first;
    it.last      = last;
    pending_items.push_back(it);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_mark();
    case ($urandom_range(0, 4))
      0: return 8'hFB;
      1: return 8'hF8;
      2: return 8'hFA;
      3: return 8'hF9;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mark plus n data bytes; leave the field open when close is low
  function automatic int queue_field(input int n, input logic close);
    int i;
    queue_item(pick_mark(), 1'b1, close && n == 0);
    for (i = 0; i < n; i++) begin
      queue_item(BYTE_W'($urandom_range(0, 255)), 1'b0, close && i == n - 1);
    end
    return n + 1;
  endfunction

  initial begin
    int count;
    int r;
    int n;
    logic dd;
    logic dbl;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    dd_shadow = 1'b0;
    dbl_shadow = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 47;
    errors = 0;
    phase_cnt = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // data before any mark runs on from the reset CRC
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    // mark and last on one item
    queue_item(8'hFB, 1'b1, 1'b1);
    queue_item(8'hFB, 1'b1, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'h55, 1'b0, 1'b0);
    queue_item(8'hAA, 1'b0, 1'b0);
    queue_item(8'h01, 1'b0, 1'b1);
    // continue past a closed field without a new mark
    queue_item(8'h80, 1'b0, 1'b0);
    queue_item(8'h7F, 1'b0, 1'b1);
    drain_and_settle();

    set_config(1'b1, 1'b1);
    queue_item(8'hF8, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0);
    drain_and_settle();
    // registers change inside an open field
    set_config(1'b0, 1'b0);
    queue_item(8'h12, 1'b0, 1'b0);
    queue_item(8'h34, 1'b0, 1'b1);
    queue_item(8'hA1, 1'b1, 1'b1);
    drain_and_settle();

    for (phase_cnt = 0; phase_cnt < NUM_PHASES; phase_cnt++) begin
      if (phase_cnt < 4) begin
        dd  = phase_cnt[0];
        dbl = phase_cnt[1];
      end else begin
        dd  = 1'($urandom_range(0, 1));
        dbl = 1'($urandom_range(0, 1));
      end
      set_config(dd, dbl);
      if (phase_cnt < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 47;
      end else if (phase_cnt < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          queue_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          count++;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 85) begin
            n = $urandom_range(0, 15);
          end else if (r < 96) begin
            n = $urandom_range(16, 64);
          end else begin
            n = $urandom_range(128, 256);
          end
          // keep the phase within its item budget
          if (n > ITEMS_PER_PHASE - count - 1) begin
            n = ITEMS_PER_PHASE - count - 1;
          end
          count += queue_field(n, $urandom_range(0, 4) != 0);
        end
      end
      drain_and_settle();
    end

    if (track_expect_q.size() != 0) begin
      errors++;
    end
    $display("ran %0d items over %0d closed fields (%0d doubled), %0d track bytes checked",
             items_taken, fields_closed, dbl_fields, results_seen);
    $display("density and doubling in all four settings, changes inside open fields, %0d bad",
             mismatches);
    if (mismatches == 0 && errors == 0) begin
      $display("[floppy_data_field_writer_crc] OK");
    end else begin
      $display("[floppy_data_field_writer_crc] ERROR");
    end
    $finish;
  end

endmodule
